FILE: sv/nfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types, codes and helpers of the nfa word acceptor.
// ----------------------------------------------------------------------------
package nfa_pkg;

    // automaton limits
    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 16;

    // field widths
    localparam int STATE_W = 4;          // state index
    localparam int SLOT_W  = 4;          // alphabet slot index
    localparam int SYM_W   = 8;          // character byte
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 5;          // count registers, 0 .. 31
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // word modes
    localparam logic [MODE_W-1:0] MODE_SYM   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALPHA = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TRANS = 2'd3;

    // register indexes
    localparam logic [1:0] REG_NUM_STATES  = 2'd0;
    localparam logic [1:0] REG_NUM_INITIAL = 2'd1;
    localparam logic [1:0] REG_FINAL_MASK  = 2'd2;
    localparam logic [1:0] REG_NUM_SYMBOLS = 2'd3;

    typedef logic [MAX_STATES-1:0] t_sset;

    // configuration register contents
    typedef struct packed {
        logic [CNT_W-1:0] num_states;
        logic [CNT_W-1:0] num_initial;
        t_sset            final_mask;
        logic [CNT_W-1:0] num_symbols;
    } t_cfg;

    // table update request
    typedef struct packed {
        logic               we_alpha;
        logic               we_trans;
        logic [SYM_W-1:0]   sym;
        logic [SLOT_W-1:0]  slot;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
    } t_load;

    // mask of states below n, saturating at MAX_STATES
    function automatic t_sset low_bits(input logic [CNT_W-1:0] n);
        t_sset m;
        for (int i = 0; i < MAX_STATES; i++) begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: sv/nfa_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_cfg_regs
// APB-style configuration registers: state count, initial count, final mask
// and symbol count.
// ----------------------------------------------------------------------------
module nfa_cfg_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [nfa_pkg::APB_AW-1:0]    paddr,
    input  wire [nfa_pkg::APB_DW-1:0]    pwdata,
    output logic [nfa_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output nfa_pkg::t_cfg                o_cfg
);
    import nfa_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_states  <= CNT_W'(MAX_STATES);
            r_cfg.num_initial <= CNT_W'(1);
            r_cfg.final_mask  <= '0;
            r_cfg.num_symbols <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_NUM_STATES:  r_cfg.num_states  <= pwdata[CNT_W-1:0];
                REG_NUM_INITIAL: r_cfg.num_initial <= pwdata[CNT_W-1:0];
                REG_FINAL_MASK:  r_cfg.final_mask  <= pwdata[MAX_STATES-1:0];
                REG_NUM_SYMBOLS: r_cfg.num_symbols <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_NUM_STATES:  prdata = APB_DW'(r_cfg.num_states);
            REG_NUM_INITIAL: prdata = APB_DW'(r_cfg.num_initial);
            REG_FINAL_MASK:  prdata = APB_DW'(r_cfg.final_mask);
            REG_NUM_SYMBOLS: prdata = APB_DW'(r_cfg.num_symbols);
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/nfa_trans_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_trans_table
// Alphabet slots and transition bitmaps, with the parallel next-set OR for
// one character over all active states and all matching slots.
// ----------------------------------------------------------------------------
module nfa_trans_table (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  nfa_pkg::t_load               i_load,
    input  wire [nfa_pkg::SYM_W-1:0]     i_sym,
    input  wire [nfa_pkg::CNT_W-1:0]     i_num_symbols,
    input  nfa_pkg::t_sset               i_cur,
    output nfa_pkg::t_sset               o_next
);
    import nfa_pkg::*;

    logic [SYM_W-1:0] r_alpha [MAX_SYMBOLS];
    t_sset            r_trans [MAX_STATES][MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] match;

    // alphabet slots and transition bitmaps, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                r_alpha[k] <= '0;
            end
            for (int s = 0; s < MAX_STATES; s++) begin
                for (int k = 0; k < MAX_SYMBOLS; k++) begin
                    r_trans[s][k] <= '0;
                end
            end
        end else begin
            if (i_load.we_alpha) begin
                r_alpha[i_load.slot] <= i_load.sym;
            end
            if (i_load.we_trans) begin
                r_trans[i_load.src][i_load.slot][i_load.dst] <= 1'b1;
            end
        end
    end

    // slots that hold the character and take part
    always_comb begin
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            match[k] = (r_alpha[k] == i_sym) && (CNT_W'(k) < i_num_symbols);
        end
    end

    // or of the bitmaps of every active state under every matching slot
    always_comb begin
        o_next = '0;
        for (int s = 0; s < MAX_STATES; s++) begin
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                if (i_cur[s] && match[k]) begin
                    o_next = o_next | r_trans[s][k];
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/nfa_word_acceptor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_word_acceptor
// Nondeterministic finite automaton run over a word, one character a word
// on the input channel, keeping the set of active states as a bit mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a mode: a character, end of word, an alphabet slot load
//   or a transition add. Only end of word yields an output word, holding the
//   accept flag and the active-state mask at the end of the word.
//   Both channels use valid/stall; a word moves when valid is high and stall
//   is low. Configuration goes through the APB-style port while idle.
//   An input word is registered in the input register, then processed into
//   the output register, from which the output word is taken.
//   Throughput: one word per cycle unless stalled; the active-set update
//   (match compare, 256-way bitmap OR) is a combinational loop on r_active.
//   When the receiver stalls with a result held, a further end-of-word waits
//   in the input register and the input channel stalls; characters and loads
//   keep flowing until then.
//   Reset (synchronous, active low) clears the active set, the alphabet slots
//   and all transitions at once, and loads the register defaults.
// ----------------------------------------------------------------------------
module nfa_word_acceptor (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [nfa_pkg::MODE_W-1:0]    i_mode,
    input  wire [nfa_pkg::SYM_W-1:0]     i_symbol,
    input  wire [nfa_pkg::SLOT_W-1:0]    i_slot,
    input  wire [nfa_pkg::STATE_W-1:0]   i_src_state,
    input  wire [nfa_pkg::STATE_W-1:0]   i_dst_state,
    // output channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_accepted,
    output logic [nfa_pkg::MAX_STATES-1:0] o_final_active,
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [nfa_pkg::APB_AW-1:0]    paddr,
    input  wire [nfa_pkg::APB_DW-1:0]    pwdata,
    output logic [nfa_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import nfa_pkg::*;

    t_cfg cfg;

    // input register
    logic               r_in_vld;
    logic [MODE_W-1:0]  r_in_mode;
    logic [SYM_W-1:0]   r_in_sym;
    logic [SLOT_W-1:0]  r_in_slot;
    logic [STATE_W-1:0] r_in_src;
    logic [STATE_W-1:0] r_in_dst;

    // word state
    t_sset r_active, n_active;
    logic  r_in_word, n_in_word;

    // output register
    logic  r_out_vld;
    logic  r_out_acc;
    t_sset r_out_fin;

    logic  out_free;
    logic  exe_go;
    logic  in_take;
    t_sset cur_set;
    t_sset next_set;
    t_load load;

    nfa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake control
    assign out_free   = !r_out_vld || !i_out_stall;
    assign exe_go     = r_in_vld && ((r_in_mode != MODE_END) || out_free);
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_vld && !exe_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!r_in_vld || exe_go) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= i_mode;
            r_in_sym  <= i_symbol;
            r_in_slot <= i_slot;
            r_in_src  <= i_src_state;
            r_in_dst  <= i_dst_state;
        end
    end

    // table loads
    always_comb begin
        load.we_alpha = exe_go && (r_in_mode == MODE_ALPHA);
        load.we_trans = exe_go && (r_in_mode == MODE_TRANS);
        load.sym      = r_in_sym;
        load.slot     = r_in_slot;
        load.src      = r_in_src;
        load.dst      = r_in_dst;
    end

    // a word starts from the initial states
    assign cur_set = r_in_word ? r_active : low_bits(cfg.num_initial);

    nfa_trans_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_sym         (r_in_sym),
        .i_num_symbols (cfg.num_symbols),
        .i_cur         (cur_set),
        .o_next        (next_set)
    );

    // active set update
    always_comb begin
        n_active  = r_active;
        n_in_word = r_in_word;
        if (exe_go) begin
            case (r_in_mode)
                MODE_SYM: begin
                    n_active  = next_set & low_bits(cfg.num_states);
                    n_in_word = 1'b1;
                end
                MODE_END: begin
                    n_active  = '0;
                    n_in_word = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_in_word <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_in_word <= n_in_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= exe_go && (r_in_mode == MODE_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (exe_go && (r_in_mode == MODE_END)) begin
            r_out_acc <= |(cur_set & cfg.final_mask);
            r_out_fin <= cur_set;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_accepted     = r_out_acc;
    assign o_final_active = r_out_fin;

`ifndef SYNTHESIS
    // a character leaves no state at or above the state count
    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exe_go && (r_in_mode == MODE_SYM)) |=>
            ((r_active & ~low_bits(cfg.num_states)) == '0))
        else $error("active set holds a state beyond the state count");

    // end of word restarts the automaton
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exe_go && (r_in_mode == MODE_END)) |=> (!r_in_word && (r_active == '0)))
        else $error("end of word did not clear the active set");

    // the accept flag agrees with the reported mask
    a_accept_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_acc == |(r_out_fin & cfg.final_mask)))
        else $error("accept flag disagrees with final states");

    // input stalls only while an end of word waits for the result register
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && (r_in_mode == MODE_END) && r_out_vld))
        else $error("input stalled without a blocked end of word");
`endif

endmodule
`default_nettype wire

FILE: bench/nfa_word_acceptor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_word_acceptor_checker
// Watches both channels and the register port of the nfa word acceptor. It
// keeps its own copy of the automaton: registers, alphabet, transitions and
// active set. From that copy it predicts the verdict of every end-of-word and
// compares it with the output word. It reports the mismatch count and the
// number of verdicts still awaited.
// ----------------------------------------------------------------------------
module nfa_word_acceptor_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input channel
    input  wire                            i_in_valid,
    input  wire                            i_in_stall,
    input  wire [nfa_pkg::MODE_W-1:0]      i_mode,
    input  wire [nfa_pkg::SYM_W-1:0]       i_symbol,
    input  wire [nfa_pkg::SLOT_W-1:0]      i_slot,
    input  wire [nfa_pkg::STATE_W-1:0]     i_src_state,
    input  wire [nfa_pkg::STATE_W-1:0]     i_dst_state,
    // output channel
    input  wire                            i_out_valid,
    input  wire                            i_out_stall,
    input  wire                            i_accepted,
    input  wire [nfa_pkg::MAX_STATES-1:0]  i_final_active,
    // register port
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [nfa_pkg::APB_AW-1:0]      paddr,
    input  wire [nfa_pkg::APB_DW-1:0]      pwdata,
    input  wire                            pready,
    // status
    output int                             o_mismatches,
    output int                             o_pending
);
    import nfa_pkg::*;

    typedef struct packed {
        logic  accepted;
        t_sset final_active;
    } t_verdict;

    // verdicts of finished words, oldest first
    t_verdict         expected_verdicts [$];
    t_verdict         oldest;

    // register copy
    logic [CNT_W-1:0] num_states_q;
    logic [CNT_W-1:0] num_initial_q;
    logic [CNT_W-1:0] num_symbols_q;
    t_sset            final_mask_q;

    // automaton copy
    t_sset            active_states;
    logic             in_word;
    logic [SYM_W-1:0] slot_chars [MAX_SYMBOLS];
    t_sset            edges [MAX_STATES][MAX_SYMBOLS];

    // states 0 .. n-1, saturating at the state limit
    function automatic t_sset first_states(input logic [CNT_W-1:0] n);
        if (n >= MAX_STATES)
            return '1;
        return t_sset'((32'd1 << n) - 32'd1);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] expv,
                                 input logic [31:0] gotv);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("nfa mismatch at %0t: %s expected %0h got %0h",
                     $realtime, what, expv, gotv);
    endtask

    // one input word through the automaton copy
    task automatic advance_automaton(input logic [MODE_W-1:0] mode,
                                     input logic [SYM_W-1:0] sym,
                                     input logic [SLOT_W-1:0] slot,
                                     input logic [STATE_W-1:0] src,
                                     input logic [STATE_W-1:0] dst);
        t_sset    reached;
        t_verdict v;
        int       nsym;
        reached = '0;
        case (mode)
            MODE_SYM: begin
                if (!in_word) begin
                    active_states = first_states(num_initial_q);
                    in_word = 1'b1;
                end
                nsym = (num_symbols_q > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(num_symbols_q);
                // every taking-part slot holding the character contributes
                for (int k = 0; k < nsym; k++) begin
                    if (slot_chars[k] == sym) begin
                        for (int s = 0; s < MAX_STATES; s++) begin
                            if (active_states[s])
                                reached |= edges[s][k];
                        end
                    end
                end
                active_states = reached & first_states(num_states_q);
            end
            MODE_END: begin
                // empty word tests the initial set itself
                if (!in_word)
                    active_states = first_states(num_initial_q);
                v.accepted = |(active_states & final_mask_q);
                v.final_active = active_states;
                expected_verdicts.push_back(v);
                active_states = '0;
                in_word = 1'b0;
            end
            MODE_ALPHA: begin
                slot_chars[slot] = sym;
            end
            MODE_TRANS: begin
                edges[src][slot][dst] = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            num_states_q = CNT_W'(MAX_STATES);
            num_initial_q = CNT_W'(1);
            num_symbols_q = '0;
            final_mask_q = '0;
            active_states = '0;
            in_word = 1'b0;
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                slot_chars[k] = '0;
                for (int s = 0; s < MAX_STATES; s++)
                    edges[s][k] = '0;
            end
            expected_verdicts.delete();
            o_mismatches = 0;
            o_pending = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_NUM_STATES:  num_states_q = pwdata[CNT_W-1:0];
                    REG_NUM_INITIAL: num_initial_q = pwdata[CNT_W-1:0];
                    REG_FINAL_MASK:  final_mask_q = pwdata[MAX_STATES-1:0];
                    REG_NUM_SYMBOLS: num_symbols_q = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            // output word against the oldest verdict
            if (i_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    note_mismatch("verdict with none awaited", '0,
                                  {i_accepted, i_final_active});
                end else begin
                    oldest = expected_verdicts.pop_front();
                    if (i_accepted !== oldest.accepted)
                        note_mismatch("accepted", oldest.accepted, i_accepted);
                    if (i_final_active !== oldest.final_active)
                        note_mismatch("final_active", oldest.final_active,
                                      i_final_active);
                end
            end
            // accepted input word
            if (i_in_valid && !i_in_stall)
                advance_automaton(i_mode, i_symbol, i_slot, i_src_state, i_dst_state);
            o_pending = expected_verdicts.size();
        end
    end

endmodule

FILE: bench/nfa_word_acceptor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_word_acceptor_tb
// Drives the nfa word acceptor with a short directed sequence (empty words,
// unknown and duplicate characters, loads inside a word, register extremes)
// and then random phases of words over a randomly built automaton. Both
// channels idle at random; one phase runs without gaps and one holds the
// output off long enough to stall the input. The checker does the prediction.
// ----------------------------------------------------------------------------
module nfa_word_acceptor_tb;
    import nfa_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode = MODE_SYM;
    logic [SYM_W-1:0]     i_symbol = '0;
    logic [SLOT_W-1:0]    i_slot = '0;
    logic [STATE_W-1:0]   i_src_state = '0;
    logic [STATE_W-1:0]   i_dst_state = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_accepted;
    t_sset                o_final_active;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int                   mismatches;
    int                   pending;
    int                   cycle_count = 0;
    int                   words_sent = 0;
    int                   random_start;
    int                   phase;
    bit                   no_idle = 1'b0;
    bit                   hold_req = 1'b0;
    bit                   hold_done = 1'b0;
    // what the stimulus has loaded into each alphabet slot
    logic [SYM_W-1:0]     loaded_chars [MAX_SYMBOLS];

    nfa_word_acceptor DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_symbol       (i_symbol),
        .i_slot         (i_slot),
        .i_src_state    (i_src_state),
        .i_dst_state    (i_dst_state),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_final_active (o_final_active),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    nfa_word_acceptor_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_symbol       (i_symbol),
        .i_slot         (i_slot),
        .i_src_state    (i_src_state),
        .i_dst_state    (i_dst_state),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_accepted     (o_accepted),
        .i_final_active (o_final_active),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(99) < 10);
            end
        end
    end

    // offer one word and wait for it to be taken; starts and ends on a falling edge
    task automatic push_word(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                             input logic [SLOT_W-1:0] slot,
                             input logic [STATE_W-1:0] src,
                             input logic [STATE_W-1:0] dst);
        while (!no_idle && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_symbol <= sym;
        i_slot <= slot;
        i_src_state <= src;
        i_dst_state <= dst;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (mode == MODE_ALPHA)
            loaded_chars[slot] = sym;
        words_sent++;
    endtask

    task automatic send_char(input logic [SYM_W-1:0] sym);
        push_word(MODE_SYM, sym, SLOT_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
    endtask

    task automatic end_word();
        push_word(MODE_END, SYM_W'($urandom), SLOT_W'($urandom), STATE_W'($urandom),
                  STATE_W'($urandom));
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [SYM_W-1:0] sym);
        push_word(MODE_ALPHA, sym, slot, STATE_W'($urandom), STATE_W'($urandom));
    endtask

    task automatic add_edge(input logic [SLOT_W-1:0] slot, input logic [STATE_W-1:0] src,
                            input logic [STATE_W-1:0] dst);
        push_word(MODE_TRANS, SYM_W'($urandom), slot, src, dst);
    endtask

    // register write, setup phase then access phase; the caller releases psel after the last one
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    // wait for every verdict, then let words without a result drain the pipe
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [4:0] n_states, input logic [4:0] n_initial,
                              input logic [15:0] f_mask, input logic [4:0] n_symbols);
        drain();
        write_reg(REG_NUM_STATES, 16'(n_states));
        write_reg(REG_NUM_INITIAL, 16'(n_initial));
        write_reg(REG_FINAL_MASK, f_mask);
        write_reg(REG_NUM_SYMBOLS, 16'(n_symbols));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // count register value, extremes and oversized values included
    function automatic logic [4:0] pick_count();
        case ($urandom_range(9))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'($urandom_range(17, 31));
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [15:0] pick_mask();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly a small letter set so that words meet the alphabet
    function automatic logic [SYM_W-1:0] pick_char();
        if ($urandom_range(4) != 0)
            return SYM_W'($urandom_range(8'h61, 8'h68));
        return SYM_W'($urandom);
    endfunction

    // a word of up to six characters with the odd load mixed in
    task automatic run_word();
        int len;
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(19))
                0: load_slot(SLOT_W'($urandom), pick_char());
                1: add_edge(SLOT_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
                2: send_char(SYM_W'($urandom));
                default: send_char(loaded_chars[$urandom_range(MAX_SYMBOLS-1)]);
            endcase
        end
        // now and then the word runs on into the next one
        if ($urandom_range(9) != 0)
            end_word();
    endtask

    // stimulus and verdict
    initial begin
        for (int k = 0; k < MAX_SYMBOLS; k++)
            loaded_chars[k] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults: empty word, then no slot takes part
        end_word();
        send_char(8'h00);
        end_word();

        // small automaton with a duplicate slot for 'a'
        set_config(5'd16, 5'd2, 16'h8003, 5'd16);
        load_slot(4'd0, 8'h61);
        load_slot(4'd1, 8'h62);
        load_slot(4'd2, 8'h61);
        load_slot(4'd3, 8'h00);
        load_slot(4'd15, 8'hFF);
        add_edge(4'd0, 4'd0, 4'd1);
        add_edge(4'd2, 4'd1, 4'd15);
        add_edge(4'd1, 4'd15, 4'd0);
        add_edge(4'd15, 4'd0, 4'd15);
        add_edge(4'd3, 4'd1, 4'd0);
        send_char(8'h61);
        send_char(8'h61);
        end_word();
        // unknown character empties the set
        send_char(8'h7A);
        end_word();
        // loads inside a word feed the characters after them
        send_char(8'h00);
        load_slot(4'd4, 8'h63);
        add_edge(4'd4, 4'd0, 4'd2);
        send_char(8'h63);
        end_word();

        // register extremes, oversized counts saturate
        set_config(5'd1, 5'd16, 16'hFFFF, 5'd31);
        send_char(8'h61);
        end_word();
        set_config(5'd31, 5'd0, 16'h0000, 5'd1);
        send_char(8'h61);
        end_word();

        // random phases
        random_start = words_sent;
        phase = 0;
        while (words_sent < random_start + RANDOM_ITEMS) begin
            set_config(pick_count(), pick_count(), pick_mask(), pick_count());
            no_idle = (phase == 2);
            hold_req = (phase == 4);
            if (phase == 0) begin
                for (int k = 0; k < MAX_SYMBOLS; k++)
                    load_slot(SLOT_W'(k), pick_char());
                repeat (60)
                    add_edge(SLOT_W'($urandom), STATE_W'($urandom), STATE_W'($urandom));
            end
            repeat ((phase == 2) ? 40 : $urandom_range(8, 30))
                run_word();
            phase++;
        end
        no_idle = 1'b0;
        hold_req = 1'b0;

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/nfa_pkg.sv
sv/nfa_cfg_regs.sv
sv/nfa_trans_table.sv
sv/nfa_word_acceptor.sv
bench/nfa_word_acceptor_checker.sv
bench/nfa_word_acceptor_tb.sv
